### hw/rtl/mbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants and types for the multi-button debouncer
// no dependencies

package mbd_pkg;

	localparam int NUM_BUTTONS = 14;
	localparam int FIELD_W     = 14;
	localparam int CNT_W       = 8;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CNT_W-1:0] PRESS_RESET   = CNT_W'(3);
	localparam logic [CNT_W-1:0] RELEASE_RESET = CNT_W'(20);

	localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = CFG_IDX_W'(1);

	typedef struct packed {
		logic stable_nxt;
		logic flip;
	} lane_out_t;

	typedef struct packed {
		logic [FIELD_W-1:0] stable;
		logic               changed;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/mbd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// one debounce lane: stable bit and settle down-counter for a single button
// depends on mbd_pkg

module mbd_lane (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      raw,
	input  wire logic [mbd_pkg::CNT_W-1:0] press_ticks,
	input  wire logic [mbd_pkg::CNT_W-1:0] release_ticks,
	output mbd_pkg::lane_out_t             lane_out
);
	import mbd_pkg::*;

	logic             stable_q;
	logic [CNT_W-1:0] cnt_q;
	logic             stable_d;
	logic [CNT_W-1:0] cnt_d;
	logic             flip;

	always_comb begin
		stable_d = stable_q;
		flip     = 1'b0;
		if (raw == stable_q) begin
			cnt_d = stable_q ? release_ticks : press_ticks;
		end else if (cnt_q <= CNT_W'(1)) begin
			// zero also expires here instead of wrapping
			stable_d = raw;
			flip     = 1'b1;
			cnt_d    = raw ? release_ticks : press_ticks;
		end else begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			cnt_q    <= PRESS_RESET;
		end else if (en) begin
			stable_q <= stable_d;
			cnt_q    <= cnt_d;
		end
	end

	assign lane_out.stable_nxt = stable_d;
	assign lane_out.flip       = flip;

endmodule

`default_nettype wire

### hw/rtl/mbd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// merges lane results into one result request and holds it in an output
// register with a skid stage; depends on mbd_pkg

module mbd_merge (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            take,
	input  mbd_pkg::lane_out_t [mbd_pkg::NUM_BUTTONS-1:0] lanes,
	output logic                                 full,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output mbd_pkg::result_t                     res
);
	import mbd_pkg::*;

	result_t merged;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    out_free;

	always_comb begin
		merged = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (i < FIELD_W) begin
				merged.stable[i] = lanes[i].stable_nxt;
			end
			merged.changed = merged.changed | lanes[i].flip;
		end
	end

	assign out_free = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || take;
				skid_valid_q <= 1'b0;
			end else if (take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= merged;
			end
		end
		if (take && !(out_free && !skid_valid_q)) begin
			skid_q <= merged;
		end
	end

	assign full      = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire

### hw/rtl/multi_button_debouncer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Multi-button debouncer, top level.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
// Each input request on in_valid/in_stall carries one raw sample of all
// buttons (raw_buttons, 1 = pressed). One result request per sample leaves on
// out_valid/out_stall: the debounced vector and a flag for any flip.
// An accepted sample's result is registered in the output register, or in the
// skid register while out_stall holds the output. Throughput is one sample per
// cycle while in_stall is low; one debounce lane per button updates its stable
// bit and settle counter in parallel, and an OR merge forms the change flag.
// When out_stall holds the result, one more sample is taken into a skid
// register; in_stall rises only once that skid register is occupied.
// press_ticks and release_ticks are written through cfg_we/cfg_index/
// cfg_data; a new value is used at the next counter reload.
// Reset clears all buttons to released, loads every counter with 3, sets
// press_ticks to 3 and release_ticks to 20, and empties the output side.

module multi_button_debouncer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [mbd_pkg::FIELD_W-1:0]   raw_buttons,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [mbd_pkg::FIELD_W-1:0]        stable_buttons,
	output logic                               any_changed,
	input  wire logic                          cfg_we,
	input  wire logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mbd_pkg::CNT_W-1:0]     cfg_data
);
	import mbd_pkg::*;

	logic [CNT_W-1:0]             press_ticks_q;
	logic [CNT_W-1:0]             release_ticks_q;
	logic                         take;
	logic                         full;
	logic [NUM_BUTTONS-1:0]       raw_ext;
	lane_out_t [NUM_BUTTONS-1:0]  lanes;
	result_t                      res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_ticks_q   <= PRESS_RESET;
			release_ticks_q <= RELEASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESS_TICKS:   press_ticks_q   <= cfg_data;
				REG_RELEASE_TICKS: release_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign take     = in_valid && !full;

	genvar g;
	generate
		for (g = 0; g < NUM_BUTTONS; g++) begin : g_lane
			// buttons past the input field always sample as released
			if (g < FIELD_W) begin : g_raw
				assign raw_ext[g] = raw_buttons[g];
			end else begin : g_zero
				assign raw_ext[g] = 1'b0;
			end

			mbd_lane u_lane (
				.clk           (clk),
				.arst_n        (arst_n),
				.en            (take),
				.raw           (raw_ext[g]),
				.press_ticks   (press_ticks_q),
				.release_ticks (release_ticks_q),
				.lane_out      (lanes[g])
			);
		end
	endgenerate

	mbd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.lanes     (lanes),
		.full      (full),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res       (res)
	);

	assign stable_buttons = res.stable;
	assign any_changed    = res.changed;

endmodule

`default_nettype wire

### hw/rtl/mbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// port-level checks for the multi-button debouncer, bound to the top level
// depends on mbd_pkg and multi_button_debouncer_unit

module mbd_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [mbd_pkg::FIELD_W-1:0]   stable_buttons,
	input  wire logic                          any_changed
);
	import mbd_pkg::*;

	// no result request while in reset, once the first reset edge has cleared the flops
	a_reset_quiet: assert property (@(posedge clk) !arst_n ##1 !arst_n |-> !out_valid)
		else $error("out_valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stable_buttons)
			&& $stable(any_changed))
		else $error("stalled result changed");

	// an accepted request always yields a pending result next cycle
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted request produced no result");

	// backpressure only once a result is waiting
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
		else $error("input stall without output stall");

endmodule

bind multi_button_debouncer_unit mbd_checker u_mbd_checker (.*);

`default_nettype wire
